// ===== design/sm4_pkg.sv =====
// Shared constants and functions for the SM4 block cipher.
// Holds the S-box, the family key FK and the tau and linear transforms.
// No dependencies.
package sm4_pkg;

  localparam int ROUNDS_DEF = 32;
  localparam int BLOCK_W = 128;
  localparam int HALF_W = 64;
  localparam int WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  // Configuration register indexes.
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW = 1'b1;

  localparam word_t FK [4] = '{32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC};

  localparam logic [7:0] SBOX [256] = '{
    8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7,
    8'h16, 8'hB6, 8'h14, 8'hC2, 8'h28, 8'hFB, 8'h2C, 8'h05,
    8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
    8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9C, 8'h42, 8'h50, 8'hF4, 8'h91, 8'hEF, 8'h98, 8'h7A,
    8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
    8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95,
    8'h80, 8'hDF, 8'h94, 8'hFA, 8'h75, 8'h8F, 8'h3F, 8'hA6,
    8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
    8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8,
    8'h68, 8'h6B, 8'h81, 8'hB2, 8'h71, 8'h64, 8'hDA, 8'h8B,
    8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
    8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2,
    8'h25, 8'h22, 8'h7C, 8'h3B, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
    8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E,
    8'hEA, 8'hBF, 8'h8A, 8'hD2, 8'h40, 8'hC7, 8'h38, 8'hB5,
    8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
    8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55,
    8'hAD, 8'h93, 8'h32, 8'h30, 8'hF5, 8'h8C, 8'hB1, 8'hE3,
    8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
    8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F,
    8'hD5, 8'hDB, 8'h37, 8'h45, 8'hDE, 8'hFD, 8'h8E, 8'h2F,
    8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
    8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F,
    8'h11, 8'hD9, 8'h5C, 8'h41, 8'h1F, 8'h10, 8'h5A, 8'hD8,
    8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
    8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0,
    8'h89, 8'h69, 8'h97, 8'h4A, 8'h0C, 8'h96, 8'h77, 8'h7E,
    8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
    8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20,
    8'h79, 8'hEE, 8'h5F, 8'h3E, 8'hD7, 8'hCB, 8'h39, 8'h48
  };

  // Byte j of constant key word i is (4*i + j) * 7 modulo 256.
  function automatic word_t ck_word(logic [7:0] idx);
    logic [7:0] b0, b1, b2, b3;
    b0 = 8'(({idx[5:0], 2'b00} + 8'd0) * 8'd7);
    b1 = 8'(({idx[5:0], 2'b00} + 8'd1) * 8'd7);
    b2 = 8'(({idx[5:0], 2'b00} + 8'd2) * 8'd7);
    b3 = 8'(({idx[5:0], 2'b00} + 8'd3) * 8'd7);
    return {b0, b1, b2, b3};
  endfunction

  function automatic word_t tau(word_t a);
    return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

  // Data path linear transform L.
  function automatic word_t l_data(word_t t);
    return t ^ {t[29:0], t[31:30]} ^ {t[21:0], t[31:22]}
             ^ {t[13:0], t[31:14]} ^ {t[7:0], t[31:8]};
  endfunction

  // Key schedule linear transform L'.
  function automatic word_t l_key(word_t t);
    return t ^ {t[18:0], t[31:19]} ^ {t[8:0], t[31:9]};
  endfunction

endpackage

// ===== design/sm4_block_cipher.sv =====
// Top level of the SM4 ECB block cipher: key schedule plus a chain of round cells.
// Depends on sm4_pkg, sm4_key_sched and sm4_round_cell.
//
// Usage:
//   Configuration: cfg_we writes cfg_data into key_high (index 0) or key_low
//   (index 1). Write only while no item is in flight.
//   Input channel: in_valid/in_ready carry mode, block_high and block_low.
//   Output channel: out_valid/out_ready carry result_high and result_low.
//
// After reset, and after every key write, the key schedule expands the key
// into ROUNDS (32 by default) round keys, one per cycle; in_ready stays
// low during that time. The all-zero key is used if no key was written.
// Once the keys are ready, one item is accepted per cycle while in_ready is
// high. Each item passes through one round cell per round; the last cell is
// the output register.
// When the receiver stalls, items pile up cell by cell behind the output
// register, and in_ready drops only once every cell holds an item.
module sm4_block_cipher #(
  parameter int ROUNDS = sm4_pkg::ROUNDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [sm4_pkg::HALF_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       mode,
  input  logic [sm4_pkg::HALF_W-1:0] block_high,
  input  logic [sm4_pkg::HALF_W-1:0] block_low,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sm4_pkg::HALF_W-1:0] result_high,
  output logic [sm4_pkg::HALF_W-1:0] result_low
);

  logic                        keys_ready;
  sm4_pkg::word_t              round_keys [ROUNDS];
  logic                        v [ROUNDS+1];
  logic                        r [ROUNDS+1];
  logic                        m [ROUNDS+1];
  logic [sm4_pkg::BLOCK_W-1:0] s [ROUNDS+1];
  logic                        unused_mode;

  sm4_key_sched #(
    .ROUNDS(ROUNDS)
  ) u_key_sched (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .keys_ready (keys_ready),
    .round_keys (round_keys)
  );

  assign v[0] = in_valid && keys_ready;
  assign m[0] = mode;
  assign s[0] = {block_high, block_low};
  assign in_ready = r[0] && keys_ready;

  for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
    sm4_round_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[i]),
      .in_ready  (r[i]),
      .in_mode   (m[i]),
      .in_state  (s[i]),
      .rk_enc    (round_keys[i]),
      .rk_dec    (round_keys[ROUNDS-1-i]),
      .out_valid (v[i+1]),
      .out_ready (r[i+1]),
      .out_mode  (m[i+1]),
      .out_state (s[i+1])
    );
  end

  assign r[ROUNDS] = out_ready;
  assign out_valid = v[ROUNDS];
  assign unused_mode = m[ROUNDS];

  // The final four words leave in reverse order.
  assign result_high = {s[ROUNDS][31:0], s[ROUNDS][63:32]};
  assign result_low = {s[ROUNDS][95:64], s[ROUNDS][127:96]};

endmodule

// ===== design/sm4_key_sched.sv =====
// Key registers and the iterative SM4 key schedule.
// One round key is produced per cycle and held in a bank of flip-flops.
// Depends on sm4_pkg.
module sm4_key_sched #(
  parameter int ROUNDS = sm4_pkg::ROUNDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [sm4_pkg::HALF_W-1:0] cfg_data,
  output logic                       keys_ready,
  output sm4_pkg::word_t             round_keys [ROUNDS]
);

  localparam int IDX_W = $clog2(ROUNDS);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ROUNDS - 1);

  logic [sm4_pkg::HALF_W-1:0]  key_high;
  logic [sm4_pkg::HALF_W-1:0]  key_low;
  logic                        busy;
  logic [IDX_W-1:0]            count;
  logic [sm4_pkg::BLOCK_W-1:0] kw;
  sm4_pkg::word_t              t;
  sm4_pkg::word_t              k_new;

  always_comb begin
    t = kw[95:64] ^ kw[63:32] ^ kw[31:0] ^ sm4_pkg::ck_word(8'(count));
    k_new = kw[127:96] ^ sm4_pkg::l_key(sm4_pkg::tau(t));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
      keys_ready <= 1'b0;
      busy <= 1'b0;
      count <= '0;
    end else if (cfg_we) begin
      // Any key write invalidates the schedule; expansion restarts afterwards.
      if (cfg_index == sm4_pkg::REG_KEY_HIGH) key_high <= cfg_data;
      if (cfg_index == sm4_pkg::REG_KEY_LOW) key_low <= cfg_data;
      keys_ready <= 1'b0;
      busy <= 1'b0;
    end else if (!keys_ready && !busy) begin
      busy <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == LAST) begin
        busy <= 1'b0;
        keys_ready <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!cfg_we && !keys_ready && !busy) begin
      kw <= {key_high, key_low} ^ {sm4_pkg::FK[0], sm4_pkg::FK[1], sm4_pkg::FK[2], sm4_pkg::FK[3]};
    end else if (busy) begin
      kw <= {kw[95:0], k_new};
      round_keys[count] <= k_new;
    end
  end

`ifndef SYNTHESIS
  a_write_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !keys_ready) else $error("key write did not clear keys_ready");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    busy |-> !keys_ready) else $error("keys_ready set during expansion");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    busy && count == LAST && !cfg_we |=> keys_ready && !busy)
    else $error("expansion did not finish after the last round");
`endif

endmodule

// ===== design/sm4_round_cell.sv =====
// One SM4 round as a pipeline cell: a registered stage with local flow control.
// The cell applies encrypt or decrypt round key as chosen by the item's mode.
// Depends on sm4_pkg.
module sm4_round_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic [sm4_pkg::BLOCK_W-1:0] in_state,
  input  sm4_pkg::word_t              rk_enc,
  input  sm4_pkg::word_t              rk_dec,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_mode,
  output logic [sm4_pkg::BLOCK_W-1:0] out_state
);

  sm4_pkg::word_t              rk;
  sm4_pkg::word_t              t;
  logic [sm4_pkg::BLOCK_W-1:0] state_next;

  always_comb begin
    rk = in_mode ? rk_dec : rk_enc;
    t = in_state[95:64] ^ in_state[63:32] ^ in_state[31:0] ^ rk;
    state_next = {in_state[95:0],
                  in_state[127:96] ^ sm4_pkg::l_data(sm4_pkg::tau(t))};
  end

  // The stage can take a new item when empty or when its item moves on.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_mode <= in_mode;
      out_state <= state_next;
    end
  end

endmodule
